>>> design/lkv_pkg.sv
`timescale 1ns / 1ps

package lkv_pkg;

	localparam int KEY_W   = 64;
	localparam int DATA_W  = 32;
	localparam int STAMP_W = 64;
	localparam int CAP_W   = 5;

	localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

	localparam logic CMD_GET    = 1'b0;
	localparam logic CMD_INSERT = 1'b1;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_LAST,
		ST_COMMIT
	} state_t;

	// control from the sequencer to the scan unit
	typedef struct packed {
		logic clear;
		logic issue;
	} scan_ctl_t;

endpackage

>>> design/lkv_if.sv
`timescale 1ns / 1ps

interface lkv_req_if;
	logic                        valid;
	logic                        ready;
	logic                        cmd;
	logic [lkv_pkg::KEY_W-1:0]   key;
	logic [lkv_pkg::DATA_W-1:0]  value;

	modport source (output valid, cmd, key, value, input ready);
	modport sink   (input valid, cmd, key, value, output ready);
endinterface

interface lkv_rsp_if;
	logic                        valid;
	logic                        ready;
	logic                        hit;
	logic [lkv_pkg::DATA_W-1:0]  read_value;
	logic                        evicted;
	logic [lkv_pkg::DATA_W-1:0]  evicted_value;

	modport source (output valid, hit, read_value, evicted, evicted_value, input ready);
	modport sink   (input valid, hit, read_value, evicted, evicted_value, output ready);
endinterface

>>> design/lkv_entry_ram.sv
`timescale 1ns / 1ps

module lkv_entry_ram #(
	parameter int DEPTH = 16,
	parameter int AW    = 4,
	parameter int DW    = 160
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [DW-1:0] wdata,
	input  logic          re,
	input  logic [AW-1:0] raddr,
	output logic [DW-1:0] rdata
);

	logic [DW-1:0] mem [DEPTH];
	logic [DW-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

>>> design/lkv_scan.sv
`timescale 1ns / 1ps

module lkv_scan #(
	parameter int AW = 4,
	parameter int VW = 32
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  lkv_pkg::scan_ctl_t            ctl,
	input  logic [AW-1:0]                 idx,
	input  logic [lkv_pkg::KEY_W-1:0]     key,
	input  logic [lkv_pkg::KEY_W-1:0]     rd_key,
	input  logic [VW-1:0]                 rd_val,
	input  logic [lkv_pkg::STAMP_W-1:0]   rd_stamp,
	output logic                          found,
	output logic [AW-1:0]                 match_idx,
	output logic [VW-1:0]                 match_val,
	output logic [AW-1:0]                 vic_idx,
	output logic [VW-1:0]                 vic_val
);

	logic                        valid_s1;
	logic [AW-1:0]               idx_s1;
	logic                        found_q;
	logic [AW-1:0]               match_idx_q;
	logic [VW-1:0]               match_val_q;
	logic [AW-1:0]               vic_idx_q;
	logic [VW-1:0]               vic_val_q;
	logic [lkv_pkg::STAMP_W-1:0] min_stamp_q;

	// read data arrives in the cycle after its address is issued
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= ctl.issue;
		end
	end

	always_ff @(posedge clk) begin
		idx_s1 <= idx;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			found_q <= 1'b0;
		end else if (ctl.clear) begin
			found_q <= 1'b0;
		end else if (valid_s1 && rd_key == key) begin
			found_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.clear) begin
			min_stamp_q <= '1;
			vic_idx_q   <= '0;
		end else if (valid_s1) begin
			if (rd_key == key) begin
				match_idx_q <= idx_s1;
				match_val_q <= rd_val;
			end
			// keep the last slot holding the oldest stamp
			if (rd_stamp <= min_stamp_q) begin
				min_stamp_q <= rd_stamp;
				vic_idx_q   <= idx_s1;
				vic_val_q   <= rd_val;
			end
		end
	end

	assign found     = found_q;
	assign match_idx = match_idx_q;
	assign match_val = match_val_q;
	assign vic_idx   = vic_idx_q;
	assign vic_val   = vic_val_q;

endmodule

>>> design/lru_key_value_cache.sv
`timescale 1ns / 1ps

// Fully associative key/value cache with least-recently-used replacement. Each request word
// is a get (look up a 64-bit key, refresh its recency on a hit) or an insert (add an absent
// key, evicting the entry with the oldest stamp once the store holds capacity entries; an
// insert of a present key changes nothing). Every request yields exactly one response word.
// All entries (key, value, stamp) live in one single-port-read, single-port-write RAM with a
// registered read; a request walks the occupied slots one per cycle, tracking the key match
// and the oldest stamp, then writes back at most one entry. The next request is taken while
// a finished response still waits in the output register. Write the capacity register only
// while the block is idle; 0 acts as 1 and values above ENTRIES act as ENTRIES.
module lru_key_value_cache #(
	parameter int ENTRIES    = 16,
	parameter int VALUE_BITS = 32
) (
	input  logic                        clk,
	input  logic                        arst_n,
	lkv_req_if.sink                     req,
	lkv_rsp_if.source                   rsp,
	input  logic                        cfg_we,
	input  logic [lkv_pkg::CAP_W-1:0]   cfg_wdata
);

	localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int CW = $clog2(ENTRIES + 1);
	localparam int VW = (VALUE_BITS < lkv_pkg::DATA_W) ? VALUE_BITS : lkv_pkg::DATA_W;
	localparam int EW = lkv_pkg::KEY_W + VW + lkv_pkg::STAMP_W;

	lkv_pkg::state_t state_q, state_d;

	logic [lkv_pkg::CAP_W-1:0]   capacity_q;
	logic [CW-1:0]               eff_cap;
	logic [CW-1:0]               count_q;
	logic [lkv_pkg::STAMP_W-1:0] ctr_q;
	logic [IW-1:0]               idx_q;

	// request held for the whole walk
	logic                        req_cmd_q;
	logic [lkv_pkg::KEY_W-1:0]   req_key_q;
	logic [VW-1:0]               req_val_q;

	// response register
	logic                        out_valid_q;
	logic                        out_hit_q;
	logic [lkv_pkg::DATA_W-1:0]  out_rv_q;
	logic                        out_ev_q;
	logic [lkv_pkg::DATA_W-1:0]  out_evv_q;

	lkv_pkg::scan_ctl_t          scan_ctl;
	logic                        accept;
	logic                        commit;
	logic                        last_slot;
	logic                        is_get;
	logic                        full;
	logic                        take_new;

	logic                        mem_we;
	logic [IW-1:0]               wr_addr;
	logic [VW-1:0]               wr_val;
	logic [EW-1:0]               wr_data;
	logic [EW-1:0]               rd_data;

	logic [lkv_pkg::KEY_W-1:0]   rd_key;
	logic [VW-1:0]               rd_val;
	logic [lkv_pkg::STAMP_W-1:0] rd_stamp;

	logic                        found;
	logic [IW-1:0]               match_idx;
	logic [VW-1:0]               match_val;
	logic [IW-1:0]               vic_idx;
	logic [VW-1:0]               vic_val;

	// Out-of-range capacity settings clamp into 1..ENTRIES.
	always_comb begin
		if (capacity_q == '0) begin
			eff_cap = CW'(1);
		end else if (int'(capacity_q) > ENTRIES) begin
			eff_cap = CW'(ENTRIES);
		end else begin
			eff_cap = CW'(capacity_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			capacity_q <= lkv_pkg::CAP_RESET;
		end else if (cfg_we) begin
			capacity_q <= cfg_wdata;
		end
	end

	assign last_slot = (CW'(idx_q) == count_q - CW'(1));
	assign accept    = req.valid && req.ready;

	// Sequencer: accept, walk the occupied slots, drain the last read, write back.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= lkv_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		req.ready = 1'b0;
		scan_ctl  = '0;
		commit    = 1'b0;
		unique case (state_q)
			lkv_pkg::ST_IDLE: begin
				req.ready = 1'b1;
				if (req.valid) begin
					scan_ctl.clear = 1'b1;
					// an empty store has nothing to walk
					state_d = (count_q == '0) ? lkv_pkg::ST_COMMIT : lkv_pkg::ST_SCAN;
				end
			end
			lkv_pkg::ST_SCAN: begin
				scan_ctl.issue = 1'b1;
				if (last_slot) begin
					state_d = lkv_pkg::ST_LAST;
				end
			end
			lkv_pkg::ST_LAST: begin
				state_d = lkv_pkg::ST_COMMIT;
			end
			lkv_pkg::ST_COMMIT: begin
				// hold until the response register is free
				if (!out_valid_q || rsp.ready) begin
					commit  = 1'b1;
					state_d = lkv_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = lkv_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			idx_q     <= '0;
			req_cmd_q <= req.cmd;
			req_key_q <= req.key;
			req_val_q <= req.value[VW-1:0];
		end else if (scan_ctl.issue && !last_slot) begin
			idx_q <= idx_q + IW'(1);
		end
	end

	// Write-back decision. Keys are unique, so a hit names one slot; stamps are unique
	// until the 64-bit counter wraps, so the victim is the one oldest entry. An eviction
	// reuses the victim's slot, leaving the fill count unchanged.
	assign is_get   = (req_cmd_q == lkv_pkg::CMD_GET);
	assign full     = (count_q >= eff_cap);
	assign take_new = !is_get && !found;
	assign mem_we   = commit && (is_get ? found : !found);
	assign wr_addr  = is_get ? match_idx : (full ? vic_idx : count_q[IW-1:0]);
	assign wr_val   = is_get ? match_val : req_val_q;
	assign wr_data  = {req_key_q, wr_val, ctr_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			ctr_q   <= '0;
		end else begin
			if (mem_we) begin
				ctr_q <= ctr_q + lkv_pkg::STAMP_W'(1);
			end
			if (commit && take_new && !full) begin
				count_q <= count_q + CW'(1);
			end
		end
	end

	lkv_entry_ram #(
		.DEPTH (ENTRIES),
		.AW    (IW),
		.DW    (EW)
	) u_ram (
		.clk   (clk),
		.we    (mem_we),
		.waddr (wr_addr),
		.wdata (wr_data),
		.re    (scan_ctl.issue),
		.raddr (idx_q),
		.rdata (rd_data)
	);

	assign rd_key   = rd_data[EW-1 -: lkv_pkg::KEY_W];
	assign rd_val   = rd_data[lkv_pkg::STAMP_W +: VW];
	assign rd_stamp = rd_data[lkv_pkg::STAMP_W-1:0];

	lkv_scan #(
		.AW (IW),
		.VW (VW)
	) u_scan (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (scan_ctl),
		.idx       (idx_q),
		.key       (req_key_q),
		.rd_key    (rd_key),
		.rd_val    (rd_val),
		.rd_stamp  (rd_stamp),
		.found     (found),
		.match_idx (match_idx),
		.match_val (match_val),
		.vic_idx   (vic_idx),
		.vic_val   (vic_val)
	);

	// Response register: load on write-back, drop once the word is taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (commit) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (commit) begin
			out_hit_q <= found;
			out_rv_q  <= (is_get && found) ? lkv_pkg::DATA_W'(match_val) : '0;
			out_ev_q  <= take_new && full;
			out_evv_q <= (take_new && full) ? lkv_pkg::DATA_W'(vic_val) : '0;
		end
	end

	assign rsp.valid         = out_valid_q;
	assign rsp.hit           = out_hit_q;
	assign rsp.read_value    = out_rv_q;
	assign rsp.evicted       = out_ev_q;
	assign rsp.evicted_value = out_evv_q;

`ifndef SYNTHESIS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		int'(count_q) <= ENTRIES)
		else $error("fill count beyond store depth");

	a_count_monotone: assert property (@(posedge clk) disable iff (!arst_n)
		1'b1 |=> count_q >= $past(count_q))
		else $error("fill count shrank");

	a_ctr_step: assert property (@(posedge clk) disable iff (!arst_n)
		1'b1 |=> (ctr_q == $past(ctr_q) || ctr_q == $past(ctr_q) + lkv_pkg::STAMP_W'(1)))
		else $error("recency counter jumped");

	a_commit_rsp: assert property (@(posedge clk) disable iff (!arst_n)
		commit |=> out_valid_q)
		else $error("write-back without response");

	a_write_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		mem_we |-> CW'(wr_addr) <= count_q)
		else $error("write beyond occupied slots");
`endif

endmodule
